### hdl/hv_serial_program_frame_engine_macros.svh
// Assertion macros shared by the checker.
`ifndef HV_SERIAL_PROGRAM_FRAME_ENGINE_MACROS_SVH
`define HV_SERIAL_PROGRAM_FRAME_ENGINE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define HVSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hvsp check failed in same cycle");

// Check that the consequent holds in the cycle after the antecedent.
`define HVSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hvsp check failed in next cycle");

`endif

### hdl/hvsp_pkg.sv
package hvsp_pkg;

    localparam int DELAY_WIDTH = 16;

    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_HIGH_FUSE   = 2'd1;
    localparam logic [1:0] CFG_LOW_FUSE    = 2'd2;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd50;
    localparam logic [7:0]  HIGH_FUSE_RST   = 8'hDF;
    localparam logic [7:0]  LOW_FUSE_RST    = 8'h62;

    localparam logic [3:0] SLOT_LAST_DATA = 4'd8;
    localparam logic [3:0] SLOT_LAST      = 4'd10;

    typedef enum logic [2:0] {
        CMD_IDLE    = 3'd0,
        CMD_RAW     = 3'd1,
        CMD_RD_LOW  = 3'd2,
        CMD_RD_HIGH = 3'd3,
        CMD_RD_EXT  = 3'd4,
        CMD_WR_HIGH = 3'd5,
        CMD_WR_LOW  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READY = 2'd1,
        PH_RUN   = 2'd2
    } t_phase;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data_byte;
        logic [7:0]  instr_byte;
        logic        sdo_level;
    } t_item;

    typedef struct packed {
        logic        valid;
        t_item       item;
    } t_head;

    typedef struct packed {
        logic        sci_level;
        logic        sdi_level;
        logic        sii_level;
        logic        busy_res;
        logic        waiting_ready;
        logic        done_res;
        logic [7:0]  read_byte;
    } t_result;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] instr_byte;
    } t_frame;

    function automatic t_frame frame_bytes(t_cmd cmd, logic [1:0] idx);
        t_frame f;
        f = '{data_byte: 8'h00, instr_byte: 8'h00};
        case (cmd)
            CMD_RD_LOW, CMD_RD_HIGH, CMD_RD_EXT: begin
                case (idx)
                    2'd0: f = '{data_byte: 8'h04, instr_byte: 8'h4C};
                    2'd1: f.instr_byte = (cmd == CMD_RD_LOW)  ? 8'h68 :
                                         (cmd == CMD_RD_HIGH) ? 8'h7A : 8'h6A;
                    2'd2: f.instr_byte = (cmd == CMD_RD_LOW)  ? 8'h6C :
                                         (cmd == CMD_RD_HIGH) ? 8'h7E : 8'h6E;
                    default: f.instr_byte = 8'h00;
                endcase
            end
            CMD_WR_HIGH, CMD_WR_LOW: begin
                case (idx)
                    2'd0: f = '{data_byte: 8'h40, instr_byte: 8'h4C};
                    2'd1: f.instr_byte = 8'h2C;
                    2'd2: f.instr_byte = (cmd == CMD_WR_HIGH) ? 8'h74 : 8'h64;
                    default: f.instr_byte = (cmd == CMD_WR_HIGH) ? 8'h7C : 8'h6C;
                endcase
            end
            default: f = '{data_byte: 8'h00, instr_byte: 8'h00};
        endcase
        return f;
    endfunction

    function automatic logic [1:0] frame_last(t_cmd cmd);
        logic [1:0] last;
        case (cmd)
            CMD_RAW:                             last = 2'd0;
            CMD_RD_LOW, CMD_RD_HIGH, CMD_RD_EXT: last = 2'd2;
            default:                             last = 2'd3;
        endcase
        return last;
    endfunction

endpackage

### hdl/hvsp_front.sv
module hvsp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [2:0]     i_func,
    input  logic [7:0]     i_data_byte,
    input  logic [7:0]     i_instr_byte,
    input  logic           i_sdo_level,
    input  logic           i_pop,
    output hvsp_pkg::t_head o_head
);
    import hvsp_pkg::*;

    t_item       r_q [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        n_wptr;
    logic        n_rptr;
    logic [1:0]  n_count;
    logic        push;
    logic        pop;
    t_item       cls;

    always_comb begin
        cls.data_byte  = i_data_byte;
        cls.instr_byte = i_instr_byte;
        cls.sdo_level  = i_sdo_level;
        unique case (i_func) inside
            CMD_RAW, CMD_RD_LOW, CMD_RD_HIGH, CMD_RD_EXT, CMD_WR_HIGH, CMD_WR_LOW:
                cls.cmd = t_cmd'(i_func);
            default: cls.cmd = CMD_IDLE;
        endcase
    end

    assign o_stall = (r_count == 2'd2);
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_count != 2'd0);

    always_comb begin
        n_wptr  = push ? ~r_wptr : r_wptr;
        n_rptr  = pop ? ~r_rptr : r_rptr;
        n_count = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_q[r_rptr];

endmodule

### hdl/hvsp_back.sv
module hvsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hvsp_pkg::t_head   i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output hvsp_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import hvsp_pkg::*;

    localparam logic [32:0] HALF_LIM = (33'd1 << DELAY_WIDTH) - 33'd1;

    logic [15:0]            r_half_period;
    logic [7:0]             r_high_fuse;
    logic [7:0]             r_low_fuse;

    t_phase                 r_phase, n_phase;
    t_cmd                   r_cmd, n_cmd;
    logic [1:0]             r_frame, n_frame;
    logic [3:0]             r_slot, n_slot;
    logic [DELAY_WIDTH-1:0] r_wait, n_wait;
    logic                   r_clock, n_clock;
    logic [7:0]             r_data, n_data;
    logic [7:0]             r_instr, n_instr;
    logic [7:0]             r_capture, n_capture;
    logic                   n_done;

    t_result                r_out, n_out;
    logic                   r_out_valid;

    logic [DELAY_WIDTH-1:0] eff_half;
    logic [32:0]            half_ext;
    t_cmd                   ld_cmd;
    logic [1:0]             ld_idx;
    t_frame                 frm;
    logic                   start;
    logic [2:0]             sh;
    t_item                  it;

    assign it    = i_head.item;
    assign o_pop = i_head.valid && (!r_out_valid || !i_stall);

    always_comb begin
        half_ext = 33'(r_half_period);
        if (half_ext == 33'd0) begin
            eff_half = DELAY_WIDTH'(1);
        end else if (half_ext > HALF_LIM) begin
            eff_half = DELAY_WIDTH'(HALF_LIM);
        end else begin
            eff_half = DELAY_WIDTH'(half_ext);
        end
    end

    assign ld_cmd = (r_phase == PH_IDLE) ? it.cmd : r_cmd;
    assign ld_idx = (r_phase == PH_IDLE) ? 2'd0 : r_frame + 2'd1;
    assign frm    = frame_bytes(ld_cmd, ld_idx);

    always_comb begin : next_state
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_frame   = r_frame;
        n_slot    = r_slot;
        n_wait    = r_wait;
        n_clock   = r_clock;
        n_data    = r_data;
        n_instr   = r_instr;
        n_capture = r_capture;
        n_done    = 1'b0;
        start     = 1'b0;
        if (o_pop) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (it.cmd != CMD_IDLE) begin
                        n_cmd   = it.cmd;
                        n_frame = 2'd0;
                        start   = 1'b1;
                        if (it.cmd == CMD_RAW) begin
                            n_data  = it.data_byte;
                            n_instr = it.instr_byte;
                        end
                    end
                end
                PH_READY: begin
                    if (it.sdo_level) begin
                        n_phase = PH_RUN;
                        n_slot  = 4'd0;
                        n_clock = 1'b1;
                        n_wait  = DELAY_WIDTH'(1);
                    end
                end
                PH_RUN: begin
                    if (r_wait < eff_half) begin
                        n_wait = r_wait + DELAY_WIDTH'(1);
                    end else if (r_clock) begin
                        n_clock = 1'b0;
                        n_wait  = DELAY_WIDTH'(1);
                    end else if (r_slot < SLOT_LAST) begin
                        n_slot  = r_slot + 4'd1;
                        n_clock = 1'b1;
                        n_wait  = DELAY_WIDTH'(1);
                        if (r_slot < SLOT_LAST_DATA) begin
                            n_capture = {r_capture[6:0], it.sdo_level};
                        end
                    end else if (r_frame < frame_last(r_cmd)) begin
                        n_frame = r_frame + 2'd1;
                        start   = 1'b1;
                    end else begin
                        n_done  = 1'b1;
                        n_phase = PH_IDLE;
                        n_cmd   = CMD_IDLE;
                        n_frame = 2'd0;
                        n_slot  = 4'd0;
                        n_wait  = '0;
                        n_clock = 1'b0;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
        if (start) begin
            if (n_cmd != CMD_RAW) begin
                n_data  = frm.data_byte;
                n_instr = frm.instr_byte;
                if (n_frame == 2'd1 && n_cmd == CMD_WR_HIGH) begin
                    n_data = r_high_fuse;
                end
                if (n_frame == 2'd1 && n_cmd == CMD_WR_LOW) begin
                    n_data = r_low_fuse;
                end
            end
            n_slot    = 4'd0;
            n_capture = 8'h00;
            if (it.sdo_level) begin
                n_phase = PH_RUN;
                n_clock = 1'b1;
                n_wait  = DELAY_WIDTH'(1);
            end else begin
                n_phase = PH_READY;
                n_clock = 1'b0;
                n_wait  = '0;
            end
        end
    end

    always_comb begin : outputs
        sh                  = 3'(4'd8 - n_slot);
        n_out.sci_level     = 1'b0;
        n_out.sdi_level     = 1'b0;
        n_out.sii_level     = 1'b0;
        n_out.busy_res      = (n_phase != PH_IDLE);
        n_out.waiting_ready = (n_phase == PH_READY);
        n_out.done_res      = n_done;
        n_out.read_byte     = n_done ? r_capture : 8'h00;
        if (n_phase == PH_RUN) begin
            n_out.sci_level = n_clock;
            if (n_slot >= 4'd1 && n_slot <= SLOT_LAST_DATA) begin
                n_out.sdi_level = n_data[sh];
                n_out.sii_level = n_instr[sh];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_high_fuse   <= HIGH_FUSE_RST;
            r_low_fuse    <= LOW_FUSE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_HIGH_FUSE:   r_high_fuse   <= i_cfg_data[7:0];
                CFG_LOW_FUSE:    r_low_fuse    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cmd       <= CMD_IDLE;
            r_frame     <= 2'd0;
            r_slot      <= 4'd0;
            r_wait      <= '0;
            r_clock     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_frame <= n_frame;
            r_slot  <= n_slot;
            r_wait  <= n_wait;
            r_clock <= n_clock;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data    <= n_data;
        r_instr   <= n_instr;
        r_capture <= n_capture;
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### hdl/hv_serial_program_frame_engine.sv
// Flow: an accepted transaction is first written into the queue, then popped from it into
// the result register once that register is free or drained, where its result waits to be taken.
// Throughput: one transaction per cycle; the tick state update in the back end
// takes one queued transaction each cycle the result register is free or drained.
// Reset: synchronous, active low; clears queue, sequencer and result valid, and
// loads half_period 50, high fuse 0xDF, low fuse 0x62.
module hv_serial_program_frame_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_instr_byte,
    input  logic        i_sdo_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_sci_level,
    output logic        o_sdi_level,
    output logic        o_sii_level,
    output logic        o_busy_res,
    output logic        o_waiting_ready,
    output logic        o_done_res,
    output logic [7:0]  o_read_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import hvsp_pkg::*;

    t_head   head;
    logic    pop;
    t_result result;

    assign o_cfg_ready = 1'b1;

    hvsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_data_byte  (i_data_byte),
        .i_instr_byte (i_instr_byte),
        .i_sdo_level  (i_sdo_level),
        .i_pop        (pop),
        .o_head       (head)
    );

    hvsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (result),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign o_sci_level     = result.sci_level;
    assign o_sdi_level     = result.sdi_level;
    assign o_sii_level     = result.sii_level;
    assign o_busy_res      = result.busy_res;
    assign o_waiting_ready = result.waiting_ready;
    assign o_done_res      = result.done_res;
    assign o_read_byte     = result.read_byte;

endmodule

### hdl/hvsp_checker.sv
`include "hv_serial_program_frame_engine_macros.svh"

module hvsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_sci_level,
    input logic       o_sdi_level,
    input logic       o_sii_level,
    input logic       o_busy_res,
    input logic       o_waiting_ready,
    input logic       o_done_res,
    input logic [7:0] o_read_byte
);

    `HVSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_read_byte) && $stable(o_done_res))
    `HVSP_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_valid && o_done_res, !o_busy_res && !o_waiting_ready)
    `HVSP_ASSERT_NOW(a_wait_busy, i_clk, i_rst_n, o_valid && o_waiting_ready, o_busy_res)
    `HVSP_ASSERT_NOW(a_byte_zero, i_clk, i_rst_n, o_valid && !o_done_res, o_read_byte == 8'h00)
    `HVSP_ASSERT_NOW(a_pins_quiet, i_clk, i_rst_n, o_valid && (o_waiting_ready || !o_busy_res), !o_sci_level && !o_sdi_level && !o_sii_level)

endmodule

bind hv_serial_program_frame_engine hvsp_checker u_hvsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_sci_level     (o_sci_level),
    .o_sdi_level     (o_sdi_level),
    .o_sii_level     (o_sii_level),
    .o_busy_res      (o_busy_res),
    .o_waiting_ready (o_waiting_ready),
    .o_done_res      (o_done_res),
    .o_read_byte     (o_read_byte)
);
